// File: hdl/efc_pkg.sv
// ----------------------------------------------------------------------------
// Elevator floor controller package
// Shared constants, phase encoding, config register map and the one-floor
// travel step used by the trip sequencer.
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam int NUM_FLOORS       = 3;
    localparam int DOOR_BLINK_TICKS = 6;

    localparam int FLOOR_W  = 2;
    localparam int LED_W    = 5;
    localparam int LIDX_W   = 3;
    localparam int CNT_W    = 5;
    localparam int DELAY_W  = 4;
    localparam int PERIOD_W = 5;
    localparam int BTN_W    = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Register index (word address) on the config port
    localparam logic REG_DOOR_DELAY   = 1'b0;
    localparam logic REG_MOVE_PERIODS = 1'b1;

    localparam logic [DELAY_W-1:0]  DOOR_DELAY_RST   = DELAY_W'(2);
    localparam logic [PERIOD_W-1:0] MOVE_PERIODS_RST = PERIOD_W'(2);
    localparam logic [LIDX_W-1:0]   LED_GROUND       = LIDX_W'(4);
    localparam logic [CNT_W-1:0]    BLINK_TICKS      = CNT_W'(DOOR_BLINK_TICKS);

    // Trip phase
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WAIT   = 5'b00010,
        PH_CLOSE  = 5'b00100,
        PH_TRAVEL = 5'b01000,
        PH_OPEN   = 5'b10000
    } phase_t;

    // Working copy of the trip state while one item is evaluated
    typedef struct packed {
        phase_t              ph;
        logic [FLOOR_W-1:0]  fn;
        logic [LIDX_W-1:0]   li;
        logic [CNT_W-1:0]    tc;
        logic                md;
        logic                go;
    } trip_t;

    // One pass of the travel phase: arrival check, midpoint LED step, floor move
    function automatic trip_t travel_pass(trip_t s, logic [FLOOR_W-1:0] tgt,
                                          logic [PERIOD_W-1:0] mp);
        trip_t             r;
        logic              up;
        logic [CNT_W-1:0]  half;
        r    = s;
        up   = (tgt > s.fn);
        half = CNT_W'(mp >> 1);
        if (s.go && (s.ph == PH_TRAVEL)) begin
            if (s.fn == tgt) begin
                r.ph = PH_OPEN;
                r.tc = '0;
            end else begin
                if (!s.md && (s.tc == half) && (s.tc < mp)) begin
                    r.li = up ? (s.li - LIDX_W'(1)) : (s.li + LIDX_W'(1));
                    r.md = 1'b1;
                end
                if (s.tc < mp) begin
                    r.go = 1'b0;
                end else begin
                    r.fn = up ? (s.fn + FLOOR_W'(1)) : (s.fn - FLOOR_W'(1));
                    r.li = up ? (r.li - LIDX_W'(1)) : (r.li + LIDX_W'(1));
                    r.tc = '0;
                    r.md = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/elevator_floor_controller.sv
// ----------------------------------------------------------------------------
// Elevator floor controller
// Three-floor elevator trip sequencer with APB config and valid/ready channels.
// ----------------------------------------------------------------------------
// Each input transaction (timer tick flag plus active-low call buttons) yields
// exactly one result transaction with the position LEDs, door lamp, current
// floor and busy flag. The full state update for one transaction is a single
// combinational pass from the state registers into the result register, so a
// transaction is accepted every clock cycle and its result appears in the
// next cycle; throughput is limited only by the result channel's ready. While idle
// the buttons are edge-detected (lowest floor wins); a trip waits door_delay
// ticks, blinks the door for six ticks, travels move_periods ticks per floor
// and blinks the door again before returning idle. Program door_delay (offset
// 0x0) and move_periods (offset 0x4) only while the block is idle.
// ----------------------------------------------------------------------------
module elevator_floor_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [efc_pkg::ADDR_W-1:0]    paddr,
    input  logic [efc_pkg::DATA_W-1:0]    pwdata,
    output logic [efc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_tick,
    input  logic [efc_pkg::BTN_W-1:0]     s_buttons_n,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [efc_pkg::LED_W-1:0]     m_position_leds_n,
    output logic                          m_door_lamp,
    output logic [efc_pkg::FLOOR_W-1:0]   m_current_floor,
    output logic                          m_busy_res
);
    import efc_pkg::*;

    // Config registers
    logic [DELAY_W-1:0]  door_delay_reg;
    logic [PERIOD_W-1:0] move_periods_reg;

    // Trip state
    phase_t              phase_reg, phase_next;
    logic [FLOOR_W-1:0]  floor_now_reg, floor_now_next;
    logic [FLOOR_W-1:0]  floor_target_reg, floor_target_next;
    logic [LIDX_W-1:0]   led_index_reg, led_index_next;
    logic [CNT_W-1:0]    tick_count_reg, tick_count_next;
    logic [BTN_W-1:0]    pressed_reg, pressed_next;
    logic                door_reg, door_next;
    logic                midpoint_reg, midpoint_next;

    // Result register
    logic                m_valid_reg;
    logic [LED_W-1:0]    leds_reg, leds_next;
    logic                lamp_reg;
    logic [FLOOR_W-1:0]  cur_floor_reg;
    logic                busy_reg;

    logic                s_fire;
    logic                cfg_wr;
    trip_t               t0, t1, t2, t3;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    // Config write and readback
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            door_delay_reg   <= DOOR_DELAY_RST;
            move_periods_reg <= MOVE_PERIODS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_DOOR_DELAY:   door_delay_reg   <= pwdata[DELAY_W-1:0];
                REG_MOVE_PERIODS: move_periods_reg <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DOOR_DELAY:   prdata = DATA_W'(door_delay_reg);
            REG_MOVE_PERIODS: prdata = DATA_W'(move_periods_reg);
            default:          prdata = '0;
        endcase
    end

    // Next trip state for one transaction
    always_comb begin
        t0.ph = phase_reg;
        t0.fn = floor_now_reg;
        t0.li = led_index_reg;
        t0.tc = tick_count_reg;
        t0.md = midpoint_reg;
        t0.go = 1'b1;
        floor_target_next = floor_target_reg;
        pressed_next      = pressed_reg;
        door_next         = door_reg;

        unique case (phase_reg)
            PH_WAIT, PH_CLOSE, PH_TRAVEL, PH_OPEN: begin
                // tick advances the running phase; no tick leaves it as is
                if (s_tick) begin
                    t0.tc = t0.tc + CNT_W'(1);
                    if ((phase_reg == PH_CLOSE) || (phase_reg == PH_OPEN)) begin
                        door_next = !door_reg;
                    end
                end else begin
                    t0.go = 1'b0;
                end
            end
            default: begin
                // idle: realign LED, open door, edge-detect buttons
                t0.ph     = PH_IDLE;
                t0.li     = LED_GROUND - LIDX_W'({floor_now_reg, 1'b0});
                door_next = 1'b1;
                for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
                    if (!s_buttons_n[i] && !pressed_reg[i]) begin
                        pressed_next[i]   = 1'b1;
                        floor_target_next = FLOOR_W'(i);
                    end else if (s_buttons_n[i] && pressed_reg[i]) begin
                        pressed_next[i] = 1'b0;
                    end
                end
                if (floor_target_next != floor_now_reg) begin
                    t0.ph = PH_WAIT;
                    t0.tc = '0;
                    t0.md = 1'b0;
                end else begin
                    t0.go = 1'b0;
                end
            end
        endcase

        // wait -> close
        if (t0.go && (t0.ph == PH_WAIT) && (t0.tc >= CNT_W'(door_delay_reg))) begin
            t0.ph = PH_CLOSE;
            t0.tc = '0;
        end
        // close -> travel
        if (t0.go && (t0.ph == PH_CLOSE) && (t0.tc >= BLINK_TICKS)) begin
            door_next = 1'b0;
            t0.ph     = PH_TRAVEL;
            t0.tc     = '0;
            t0.md     = 1'b0;
        end

        // up to two floor moves plus arrival in one transaction
        t1 = travel_pass(t0, floor_target_next, move_periods_reg);
        t2 = travel_pass(t1, floor_target_next, move_periods_reg);
        t3 = travel_pass(t2, floor_target_next, move_periods_reg);

        // open -> idle
        if (t3.go && (t3.ph == PH_OPEN) && (t3.tc >= BLINK_TICKS)) begin
            door_next = 1'b1;
            t3.ph     = PH_IDLE;
        end

        phase_next      = t3.ph;
        floor_now_next  = t3.fn;
        led_index_next  = t3.li;
        tick_count_next = t3.tc;
        midpoint_next   = t3.md;
    end

    // Active-low one-hot LED decode; indexes past the ground LED light nothing
    always_comb begin
        for (int j = 0; j < LED_W; j++) begin
            leds_next[j] = (led_index_next != LIDX_W'(j));
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            floor_now_reg    <= '0;
            floor_target_reg <= '0;
            led_index_reg    <= LED_GROUND;
            tick_count_reg   <= '0;
            pressed_reg      <= '0;
            door_reg         <= 1'b1;
            midpoint_reg     <= 1'b0;
        end else if (s_fire) begin
            phase_reg        <= phase_next;
            floor_now_reg    <= floor_now_next;
            floor_target_reg <= floor_target_next;
            led_index_reg    <= led_index_next;
            tick_count_reg   <= tick_count_next;
            pressed_reg      <= pressed_next;
            door_reg         <= door_next;
            midpoint_reg     <= midpoint_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            leds_reg      <= leds_next;
            lamp_reg      <= door_next;
            cur_floor_reg <= floor_now_next;
            busy_reg      <= (phase_next != PH_IDLE);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_position_leds_n = leds_reg;
    assign m_door_lamp       = lamp_reg;
    assign m_current_floor   = cur_floor_reg;
    assign m_busy_res        = busy_reg;

endmodule
